>>> src/hpmc_pkg.sv
// Shared types and constants of the half-pel motion compensation core.
`timescale 1ns / 1ps

package hpmc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int MODE_W   = 3;
    localparam int SIZE_W   = 2;
    localparam int FL_W     = 2;

    // mode bits
    localparam int MODE_BIT_HX  = 0;
    localparam int MODE_BIT_HY  = 1;
    localparam int MODE_BIT_AVG = 2;

    // block size codes
    localparam logic [SIZE_W-1:0] SIZE_16X16 = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16X8  = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_8X8   = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_8X4   = 2'd3;

    // one window sample on its way from the sequencer to the blend stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] prev;
        logic                hx;
        logic                hy;
        logic                avg;
        logic                up_ok;
        logic                emit;
        logic                last;
    } hpmc_item_t;

endpackage

>>> src/hpmc_if.sv
// Valid/ready channel interfaces for reference samples and predictions.
`timescale 1ns / 1ps

interface hpmc_in_if
    import hpmc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                first;
    logic [MODE_W-1:0]   mode;
    logic [SIZE_W-1:0]   size;
    logic [FL_W-1:0]     field_lines;

    modport source (output valid, sample, first, mode, size, field_lines, input ready);
    modport sink   (input valid, sample, first, mode, size, field_lines, output ready);
endinterface

interface hpmc_out_if
    import hpmc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] pred_sample;
    logic                last;

    modport source (output valid, pred_sample, last, input ready);
    modport sink   (input valid, pred_sample, last, output ready);
endinterface

>>> src/hpmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // a read at the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/hpmc_seq.sv
// Window sequencer: block settings, window position and store addresses.
`timescale 1ns / 1ps

module hpmc_seq
    import hpmc_pkg::*;
#(
    parameter int MAX_WIDTH       = 16,
    parameter int MAX_HEIGHT      = 16,
    parameter int MAX_FIELD_LINES = 2,
    localparam int ROW_SLOTS  = MAX_WIDTH + 1,
    localparam int LINE_DEPTH = MAX_FIELD_LINES * ROW_SLOTS,
    localparam int PRED_DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int LAW        = $clog2(LINE_DEPTH),
    localparam int PAW        = $clog2(PRED_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                first,
    input  logic [MODE_W-1:0]   mode,
    input  logic [SIZE_W-1:0]   size,
    input  logic [FL_W-1:0]     field_lines,
    output hpmc_item_t          item,
    output logic [LAW-1:0]      line_rd_addr,
    output logic [LAW-1:0]      line_wr_addr,
    output logic [PAW-1:0]      pred_addr
);

    localparam int WIN_MAX = (MAX_WIDTH + 2 > MAX_HEIGHT + MAX_FIELD_LINES + 1)
                           ? MAX_WIDTH + 2 : MAX_HEIGHT + MAX_FIELD_LINES + 1;
    localparam int CW = $clog2(WIN_MAX);

    localparam logic [CW-1:0] W_WIDE   = CW'((MAX_WIDTH < 16) ? MAX_WIDTH : 16);
    localparam logic [CW-1:0] W_NARROW = CW'((MAX_WIDTH < 8) ? MAX_WIDTH : 8);
    localparam logic [CW-1:0] H_TALL   = CW'((MAX_HEIGHT < 16) ? MAX_HEIGHT : 16);
    localparam logic [CW-1:0] H_MID    = CW'((MAX_HEIGHT < 8) ? MAX_HEIGHT : 8);
    localparam logic [CW-1:0] H_SHORT  = CW'((MAX_HEIGHT < 4) ? MAX_HEIGHT : 4);
    localparam logic [FL_W-1:0] FL_MAX = FL_W'(MAX_FIELD_LINES);

    logic [CW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [FL_W-1:0]     fl_reg;
    logic [SAMPLE_W-1:0] prev_reg;

    logic [MODE_W-1:0]   mode_c;
    logic [SIZE_W-1:0]   size_c;
    logic [FL_W-1:0]     fl_c;
    logic [FL_W-1:0]     fl_in;
    logic [CW-1:0]       row_c, col_c;
    logic [CW-1:0]       blk_w, blk_h;
    logic [CW-1:0]       win_w, win_h;
    logic [CW-1:0]       hyfl;
    logic [CW-1:0]       wr, wc;
    logic [CW-1:0]       up_row;
    logic [CW-1:0]       r, c;
    logic                hx, hy;

    always_comb
    begin
        if (field_lines == '0)
        begin
            fl_in = FL_W'(1);
        end
        else if (field_lines > FL_MAX)
        begin
            fl_in = FL_MAX;
        end
        else
        begin
            fl_in = field_lines;
        end

        mode_c = first ? mode : mode_reg;
        size_c = first ? size : size_reg;
        fl_c   = first ? fl_in : fl_reg;
        row_c  = first ? '0 : row_reg;
        col_c  = first ? '0 : col_reg;

        case (size_c)
            SIZE_16X16: begin blk_w = W_WIDE;   blk_h = H_TALL;  end
            SIZE_16X8:  begin blk_w = W_WIDE;   blk_h = H_MID;   end
            SIZE_8X8:   begin blk_w = W_NARROW; blk_h = H_MID;   end
            SIZE_8X4:   begin blk_w = W_NARROW; blk_h = H_SHORT; end
            default:    begin blk_w = W_WIDE;   blk_h = H_TALL;  end
        endcase

        hx    = mode_c[MODE_BIT_HX];
        hy    = mode_c[MODE_BIT_HY];
        hyfl  = hy ? CW'(fl_c) : '0;
        win_w = blk_w + CW'(hx);
        win_h = blk_h + hyfl;

        // keep the position inside the window
        wr = (row_c >= win_h) ? '0 : row_c;
        wc = (col_c >= win_w) ? '0 : col_c;

        // advance raster position, wrap at the window end
        col_next = wc + CW'(1);
        row_next = wr;
        if (col_next >= win_w)
        begin
            col_next = '0;
            row_next = wr + CW'(1);
            if (row_next >= win_h)
            begin
                row_next = '0;
            end
        end

        up_row = wr - CW'(fl_c);
        r      = wr - hyfl;
        c      = wc - CW'(hx);

        line_rd_addr = LAW'(int'(up_row % MAX_FIELD_LINES) * ROW_SLOTS + int'(wc));
        line_wr_addr = LAW'(int'(wr % MAX_FIELD_LINES) * ROW_SLOTS + int'(wc));
        pred_addr    = PAW'(int'(r) * MAX_WIDTH + int'(c));

        item.sample = sample;
        item.prev   = prev_reg;
        item.hx     = hx;
        item.hy     = hy;
        item.avg    = mode_c[MODE_BIT_AVG];
        item.up_ok  = (wr >= CW'(fl_c));
        item.emit   = (wr >= hyfl) && (wc >= CW'(hx));
        item.last   = (r == blk_h - CW'(1)) && (c == blk_w - CW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            mode_reg <= '0;
            size_reg <= SIZE_16X16;
            fl_reg   <= FL_W'(1);
            prev_reg <= '0;
        end
        else if (acc)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            mode_reg <= mode_c;
            size_reg <= size_c;
            fl_reg   <= fl_c;
            prev_reg <= sample;
        end
    end

endmodule

>>> src/hpmc_blend.sv
// Half-pel interpolation and averaging against the stored prediction.
`timescale 1ns / 1ps

module hpmc_blend
    import hpmc_pkg::*;
(
    input  hpmc_item_t          item,
    input  logic [SAMPLE_W-1:0] upper_left,
    input  logic [SAMPLE_W-1:0] line_rd,
    input  logic [SAMPLE_W-1:0] pred_old,
    output logic [SAMPLE_W-1:0] up_val,
    output logic [SAMPLE_W-1:0] pred
);

    logic [SAMPLE_W+1:0] sum4;
    logic [SAMPLE_W:0]   sum_h;
    logic [SAMPLE_W:0]   sum_v;
    logic [SAMPLE_W:0]   sum_a;
    logic [SAMPLE_W-1:0] interp;

    always_comb
    begin
        up_val = item.up_ok ? line_rd : '0;

        sum4  = (SAMPLE_W+2)'(upper_left) + (SAMPLE_W+2)'(up_val)
              + (SAMPLE_W+2)'(item.prev) + (SAMPLE_W+2)'(item.sample)
              + (SAMPLE_W+2)'(2);
        sum_h = (SAMPLE_W+1)'(item.prev) + (SAMPLE_W+1)'(item.sample) + (SAMPLE_W+1)'(1);
        sum_v = (SAMPLE_W+1)'(up_val) + (SAMPLE_W+1)'(item.sample) + (SAMPLE_W+1)'(1);

        if (item.hx && item.hy)
        begin
            interp = sum4[SAMPLE_W+1:2];
        end
        else if (item.hx)
        begin
            interp = sum_h[SAMPLE_W:1];
        end
        else if (item.hy)
        begin
            interp = sum_v[SAMPLE_W:1];
        end
        else
        begin
            interp = item.sample;
        end

        sum_a = (SAMPLE_W+1)'(pred_old) + (SAMPLE_W+1)'(interp) + (SAMPLE_W+1)'(1);
        pred  = item.avg ? sum_a[SAMPLE_W:1] : interp;
    end

endmodule

>>> src/half_pel_motion_compensation_core.sv
// Half-pel motion compensation core: top level with line and prediction stores.
// Path: after its completing sample is accepted, a prediction reaches the output
// via the store read into the blend stage, then the blend into the output register.
// Throughput: one reference sample per clock unless stalled; line and prediction
// stores are read and written once per cycle; a full output stalls emitting samples.
// Reset: rst_n clears the pipeline, window position, previous and upper-left
// samples and the block settings (16x16, copy, one line); store contents persist.
`timescale 1ns / 1ps

module half_pel_motion_compensation_core
    import hpmc_pkg::*;
#(
    parameter int MAX_WIDTH       = 16,
    parameter int MAX_HEIGHT      = 16,
    parameter int MAX_FIELD_LINES = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    hpmc_in_if.sink     samples,
    hpmc_out_if.source  preds
);

    localparam int ROW_SLOTS  = MAX_WIDTH + 1;
    localparam int LINE_DEPTH = MAX_FIELD_LINES * ROW_SLOTS;
    localparam int PRED_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int LAW        = $clog2(LINE_DEPTH);
    localparam int PAW        = $clog2(PRED_DEPTH);

    hpmc_item_t          acc_item;
    logic [LAW-1:0]      line_rd_addr;
    logic [LAW-1:0]      line_wr_addr;
    logic [PAW-1:0]      acc_pred_addr;
    logic                acc;

    logic [SAMPLE_W-1:0] line_rd;
    logic [SAMPLE_W-1:0] pred_rd;
    logic [SAMPLE_W-1:0] pred_old;
    logic [SAMPLE_W-1:0] up_val;
    logic [SAMPLE_W-1:0] pred;
    logic                s1_adv;
    logic                pred_we;

    logic                s1_valid_reg, s1_valid_next;
    hpmc_item_t          s1_item_reg;
    logic [PAW-1:0]      s1_pidx_reg;
    logic                byp_hit_reg;
    logic [SAMPLE_W-1:0] byp_data_reg;
    logic [SAMPLE_W-1:0] ul_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_last_reg;

    hpmc_seq #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .MAX_FIELD_LINES (MAX_FIELD_LINES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (acc),
        .sample       (samples.sample),
        .first        (samples.first),
        .mode         (samples.mode),
        .size         (samples.size),
        .field_lines  (samples.field_lines),
        .item         (acc_item),
        .line_rd_addr (line_rd_addr),
        .line_wr_addr (line_wr_addr),
        .pred_addr    (acc_pred_addr)
    );

    // line store: read the upper neighbour and write the new sample in the accept cycle
    hpmc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (acc),
        .wr_addr (line_wr_addr),
        .wr_data (samples.sample),
        .re      (acc),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd)
    );

    hpmc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (PRED_DEPTH)
    ) u_pred_ram (
        .clk     (clk),
        .we      (pred_we),
        .wr_addr (s1_pidx_reg),
        .wr_data (pred),
        .re      (acc),
        .rd_addr (acc_pred_addr),
        .rd_data (pred_rd)
    );

    // a write landing in the same cycle as the read is not in the read data
    assign pred_old = byp_hit_reg ? byp_data_reg : pred_rd;

    hpmc_blend u_blend (
        .item       (s1_item_reg),
        .upper_left (ul_reg),
        .line_rd    (line_rd),
        .pred_old   (pred_old),
        .up_val     (up_val),
        .pred       (pred)
    );

    assign s1_adv  = s1_valid_reg && (!s1_item_reg.emit || !out_valid_reg || preds.ready);
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign acc     = samples.valid && samples.ready;
    assign pred_we = s1_adv && s1_item_reg.emit;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pred_we)
        begin
            out_valid_next = 1'b1;
        end
        else if (preds.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ul_reg        <= '0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                ul_reg <= up_val;
            end
            if (acc)
            begin
                byp_hit_reg <= pred_we && (s1_pidx_reg == acc_pred_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_item_reg  <= acc_item;
            s1_pidx_reg  <= acc_pred_addr;
            byp_data_reg <= pred;
        end
        if (pred_we)
        begin
            out_data_reg <= pred;
            out_last_reg <= s1_item_reg.last;
        end
    end

    assign preds.valid       = out_valid_reg;
    assign preds.pred_sample = out_data_reg;
    assign preds.last        = out_last_reg;

    // hold input while the blend stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !samples.ready)
        else $error("input taken while blend stage is stalled");

    // a blocked prediction stays in the blend stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_item_reg.emit && out_valid_reg && !preds.ready |=> s1_valid_reg)
        else $error("prediction dropped from blend stage");

    // prediction store is written only when the output register can take the result
    assert property (@(posedge clk) disable iff (!rst_n)
        pred_we |-> (!out_valid_reg || preds.ready))
        else $error("prediction written over a pending result");

    // every accepted sample reaches the blend stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s1_valid_reg)
        else $error("accepted sample missing from blend stage");

endmodule
